/* rtl/core/tccw_pkg.sv */
// Shared types, constants and codes for the text console cursor writer.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Cursor storage widths cover the largest supported geometry.
    localparam int COL_W = 7;
    localparam int ROW_W = 6;

    // Depth of the command queue and of the result queue.
    localparam int QUEUE_DEPTH = 4;

    // Character codes.
    localparam logic [7:0] CHAR_END       = 8'h00;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BLANK     = 8'h20;

    // Operation codes of an input item.
    localparam logic [1:0] OP_PUT_MAIN  = 2'd0;
    localparam logic [1:0] OP_PUT_SIDE  = 2'd1;
    localparam logic [1:0] OP_LOAD_SIDE = 2'd2;
    localparam logic [1:0] OP_HOME_MAIN = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd1;

    // Reset colors.
    localparam logic [3:0] RESET_FOREGROUND = 4'hF;
    localparam logic [3:0] RESET_BACKGROUND = 4'h0;

    // Command kinds decided by the front end.
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_NONE      = 3'd0;
    localparam t_kind KIND_BACKSPACE = 3'd1;
    localparam t_kind KIND_NEWLINE   = 3'd2;
    localparam t_kind KIND_PRINT     = 3'd3;
    localparam t_kind KIND_LOAD      = 3'd4;
    localparam t_kind KIND_HOME      = 3'd5;

    // One input item.
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic [6:0] pos_x;
        logic [4:0] pos_y;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        write_valid;
        logic [10:0] cell_index;
        logic [15:0] cell_value;
        logic        screen_cleared;
        logic [6:0]  cursor_x;
        logic [4:0]  cursor_y;
    } t_out_item;

    // A classified command passed from the front end to the back end.
    typedef struct packed {
        t_kind            kind;
        logic             use_side;
        logic [7:0]       char_code;
        logic [COL_W-1:0] load_col;
        logic [4:0]       load_row;
    } t_cmd;

endpackage : tccw_pkg

`default_nettype wire

/* rtl/core/tccw_fifo.sv */
// Small first-word fall-through queue built from registers.
`timescale 1ns / 1ps
`default_nettype none

module tccw_fifo
    import tccw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule : tccw_fifo

`default_nettype wire

/* rtl/core/tccw_front.sv */
// Front end: classifies each input item into a command for the back end.
`timescale 1ns / 1ps
`default_nettype none

module tccw_front
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire t_in_item i_item,
    output t_cmd          o_cmd
);

    localparam logic [7:0]       COLS_K   = 8'(COLUMNS);
    localparam logic [6:0]       ROWS_K   = 7'(ROWS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [4:0]       LAST_ROW = 5'(ROWS - 1);

    // Decode the operation and the character class.
    always_comb begin
        o_cmd.char_code = i_item.char_code;
        o_cmd.use_side  = (i_item.operation == OP_PUT_SIDE) ||
                          (i_item.operation == OP_LOAD_SIDE);
        o_cmd.load_col  = ({1'b0, i_item.pos_x} >= COLS_K) ? LAST_COL : i_item.pos_x;
        o_cmd.load_row  = ({2'b00, i_item.pos_y} >= ROWS_K) ? LAST_ROW : i_item.pos_y;
        unique case (i_item.operation)
            OP_PUT_MAIN, OP_PUT_SIDE: begin
                if (i_item.char_code == CHAR_END) begin
                    o_cmd.kind = KIND_NONE;
                end else if (i_item.char_code == CHAR_BACKSPACE) begin
                    o_cmd.kind = KIND_BACKSPACE;
                end else if (i_item.char_code == CHAR_NEWLINE) begin
                    o_cmd.kind = KIND_NEWLINE;
                end else begin
                    o_cmd.kind = KIND_PRINT;
                end
            end
            OP_LOAD_SIDE: begin
                o_cmd.kind = KIND_LOAD;
            end
            default: begin
                o_cmd.kind = KIND_HOME;
            end
        endcase
    end

endmodule : tccw_front

`default_nettype wire

/* rtl/core/tccw_back.sv */
// Back end: holds both cursors and turns each command into a result item.
`timescale 1ns / 1ps
`default_nettype none

module tccw_back
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_attr,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_cmd_valid,
    input  wire logic       i_res_full,
    output logic            o_cmd_pop,
    output t_out_item       o_result
);

    localparam logic [7:0]  COLS_K = 8'(COLUMNS);
    localparam logic [6:0]  ROWS_K = 7'(ROWS);
    localparam logic [13:0] COLS_M = 14'(COLUMNS);

    logic [COL_W-1:0] r_main_col, n_main_col;
    logic [ROW_W-1:0] r_main_row, n_main_row;
    logic [COL_W-1:0] r_side_col, n_side_col;
    logic [ROW_W-1:0] r_side_row, n_side_row;

    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] wr_col;
    logic [7:0]       col_next;
    logic [6:0]       row_next;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [13:0]      addr_full;
    logic             is_char;
    logic             step;

    assign step      = i_cmd_valid && !i_res_full;
    assign o_cmd_pop = step;

    assign cur_col = i_cmd.use_side ? r_side_col : r_main_col;
    assign cur_row = i_cmd.use_side ? r_side_row : r_main_row;
    assign is_char = (i_cmd.kind == KIND_PRINT) || (i_cmd.kind == KIND_BACKSPACE) ||
                     (i_cmd.kind == KIND_NEWLINE);

    // Backspace writes at the column it steps back to.
    assign wr_col = (i_cmd.kind == KIND_BACKSPACE && cur_col != '0) ?
                    cur_col - 1'b1 : cur_col;
    assign addr_full = 14'(cur_row) * COLS_M + 14'(wr_col);

    // Cursor movement, line wrap and screen end.
    always_comb begin
        o_result                = '0;
        col_next                = {1'b0, cur_col};
        row_next                = {1'b0, cur_row};
        out_col                 = cur_col;
        out_row                 = cur_row;
        case (i_cmd.kind)
            KIND_PRINT: begin
                o_result.write_valid = 1'b1;
                o_result.cell_index  = addr_full[10:0];
                o_result.cell_value  = {i_attr, i_cmd.char_code};
                col_next             = {1'b0, cur_col} + 8'd1;
            end
            KIND_BACKSPACE: begin
                o_result.write_valid = 1'b1;
                o_result.cell_index  = addr_full[10:0];
                o_result.cell_value  = {i_attr, CHAR_BLANK};
                col_next             = {1'b0, wr_col};
            end
            KIND_NEWLINE: begin
                col_next = '0;
                row_next = {1'b0, cur_row} + 7'd1;
            end
            default: begin
            end
        endcase
        if (col_next >= COLS_K) begin
            col_next = '0;
            row_next = {1'b0, cur_row} + 7'd1;
        end
        if (row_next >= ROWS_K) begin
            o_result.screen_cleared = 1'b1;
            col_next                = '0;
            row_next                = '0;
        end
        if (is_char) begin
            out_col = col_next[COL_W-1:0];
            out_row = row_next[ROW_W-1:0];
        end else if (i_cmd.kind == KIND_LOAD) begin
            out_col = i_cmd.load_col;
            out_row = ROW_W'(i_cmd.load_row);
        end else if (i_cmd.kind == KIND_HOME) begin
            out_col = '0;
            out_row = '0;
        end
        o_result.cursor_x = out_col;
        o_result.cursor_y = out_row[4:0];
    end

    // Write back the cursor that the command used.
    always_comb begin
        n_main_col = r_main_col;
        n_main_row = r_main_row;
        n_side_col = r_side_col;
        n_side_row = r_side_row;
        if (step) begin
            if (i_cmd.use_side) begin
                n_side_col = out_col;
                n_side_row = out_row;
            end else begin
                n_main_col = out_col;
                n_main_row = out_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_col <= '0;
            r_main_row <= '0;
            r_side_col <= '0;
            r_side_row <= '0;
        end else begin
            r_main_col <= n_main_col;
            r_main_row <= n_main_row;
            r_side_col <= n_side_col;
            r_side_row <= n_side_row;
        end
    end

endmodule : tccw_back

`default_nettype wire

/* rtl/core/text_console_cursor_writer.sv */
// Top level of the text console cursor writer: front end, queues and back end.
//
//  Channel   Direction  Handshake            Payload
//  input     in         push / full          i_item   (t_in_item)
//  result    out        empty / pop          o_result (t_out_item)
//  config    in         i_cfg_we, no wait    i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while the command queue is not full, and one
// result is delivered per cycle while the result queue is not empty. A result
// shows on o_result after its item passes the command queue, where the back end
// updates the cursor from the queue head, and then the result queue, which takes
// it unless full. The cursor registers are updated once per command, which sets
// the rate. Reset homes both cursors, sets white on black and empties both
// queues. Either side may stall; each queue absorbs up to four items.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire t_in_item             i_item,
    output logic                      empty,
    input  wire logic                 pop,
    output t_out_item                 o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [3:0]           i_cfg_data
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_out_item);

    logic [3:0] r_foreground;
    logic [3:0] r_background;
    t_cmd       front_cmd;
    t_cmd       back_cmd;
    logic       cmd_empty;
    logic       cmd_pop;
    logic       res_full;
    t_out_item  back_result;

    // Color registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_foreground <= RESET_FOREGROUND;
            r_background <= RESET_BACKGROUND;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOREGROUND: r_foreground <= i_cfg_data;
                default:        r_background <= i_cfg_data;
            endcase
        end
    end

    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_item (i_item),
        .o_cmd  (front_cmd)
    );

    // Queue of classified commands between front and back.
    tccw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      ({r_background, r_foreground}),
        .i_cmd       (back_cmd),
        .i_cmd_valid (!cmd_empty),
        .i_res_full  (res_full),
        .o_cmd_pop   (cmd_pop),
        .o_result    (back_result)
    );

    // Result queue toward the consumer.
    tccw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_pop),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule : text_console_cursor_writer

`default_nettype wire

/* test/tb_text_console_cursor_writer.sv */
// Self-checking testbench for the text console cursor writer.
`timescale 1ns / 1ps
`default_nettype none

module tb_text_console_cursor_writer;
    import tccw_pkg::*;

    localparam int SCREEN_COLUMNS = DEF_COLUMNS;
    localparam int SCREEN_ROWS    = DEF_ROWS;
    localparam int ITEMS_PER_PHASE = 216;

    // Block ports; the inputs are at known values from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    t_in_item             i_item      = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    t_out_item            o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [3:0]           i_cfg_data  = '0;

    // Predicted console state and color settings.
    logic [3:0] cur_fg = RESET_FOREGROUND;
    logic [3:0] cur_bg = RESET_BACKGROUND;
    int main_col = 0;
    int main_row = 0;
    int side_col = 0;
    int side_row = 0;

    // Items waiting to be sent and results waiting to arrive.
    t_in_item  pending_items[$];
    t_out_item expected_cells[$];

    // Run bookkeeping.
    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int clears_seen   = 0;
    int writes_seen   = 0;
    int full_cycles   = 0;
    int color_changes = 0;

    // Handshake pacing on both sides.
    int push_gap   = 0;
    int push_burst = 0;
    int pop_gap    = 0;
    int pop_burst  = 0;
    int hold_left  = 0;

    text_console_cursor_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Idle length between handshakes: mostly short, a few long, sometimes a gapless burst.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 4) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one character to a cursor, filling in the write and clear fields.
    function automatic void put_char_at(input logic [7:0] ch, inout int col, inout int row,
                                        inout t_out_item r);
        logic [7:0] attr;
        attr = {cur_bg, cur_fg};
        if (ch != CHAR_END) begin
            if (ch == CHAR_BACKSPACE) begin
                if (col > 0) col--;
                r.write_valid = 1'b1;
                r.cell_index  = 11'(row * SCREEN_COLUMNS + col);
                r.cell_value  = {attr, CHAR_BLANK};
            end else if (ch == CHAR_NEWLINE) begin
                col = 0;
                row++;
            end else begin
                r.write_valid = 1'b1;
                r.cell_index  = 11'(row * SCREEN_COLUMNS + col);
                r.cell_value  = {attr, ch};
                col++;
            end
            // Line wrap, then the screen clear that homes the cursor.
            if (col >= SCREEN_COLUMNS) begin
                col = 0;
                row++;
            end
            if (row >= SCREEN_ROWS) begin
                r.screen_cleared = 1'b1;
                col = 0;
                row = 0;
            end
        end
    endfunction

    // Expected result of one accepted item; updates the predicted cursors.
    function automatic t_out_item console_step(input t_in_item it);
        t_out_item r;
        int col;
        int row;
        r = '0;
        case (it.operation)
            OP_PUT_MAIN: begin
                col = main_col;
                row = main_row;
                put_char_at(it.char_code, col, row, r);
                main_col = col;
                main_row = row;
            end
            OP_PUT_SIDE: begin
                col = side_col;
                row = side_row;
                put_char_at(it.char_code, col, row, r);
                side_col = col;
                side_row = row;
            end
            OP_LOAD_SIDE: begin
                side_col = (it.pos_x >= SCREEN_COLUMNS) ? SCREEN_COLUMNS - 1 : int'(it.pos_x);
                side_row = (it.pos_y >= SCREEN_ROWS) ? SCREEN_ROWS - 1 : int'(it.pos_y);
                col = side_col;
                row = side_row;
            end
            default: begin
                main_col = 0;
                main_row = 0;
                col = 0;
                row = 0;
            end
        endcase
        r.cursor_x = 7'(col);
        r.cursor_y = 5'(row);
        return r;
    endfunction

    // Report one field that differs from its prediction.
    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    function automatic void queue_item(input logic [1:0] op, input logic [7:0] ch,
                                       input logic [6:0] x, input logic [4:0] y);
        t_in_item it;
        it.operation = op;
        it.char_code = ch;
        it.pos_x     = x;
        it.pos_y     = y;
        pending_items.push_back(it);
    endfunction

    // Random item: mostly printing with some newlines and backspaces, a few commands.
    function automatic t_in_item random_item();
        t_in_item it;
        int r;
        r = $urandom_range(99);
        if (r < 50)      it.operation = OP_PUT_MAIN;
        else if (r < 75) it.operation = OP_PUT_SIDE;
        else if (r < 93) it.operation = OP_LOAD_SIDE;
        else             it.operation = OP_HOME_MAIN;
        r = $urandom_range(99);
        if (r < 8)       it.char_code = CHAR_NEWLINE;
        else if (r < 16) it.char_code = CHAR_BACKSPACE;
        else if (r < 18) it.char_code = CHAR_END;
        else             it.char_code = 8'($urandom_range(1, 255));
        if ($urandom_range(99) < 85) begin
            it.pos_x = 7'($urandom_range(0, SCREEN_COLUMNS - 1));
            it.pos_y = 5'($urandom_range(0, SCREEN_ROWS - 1));
        end else begin
            it.pos_x = 7'($urandom);
            it.pos_y = 5'($urandom);
        end
        return it;
    endfunction

    // Wait until every item is sent and every result is back, then let the pipe settle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || push || expected_cells.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both color registers; only called while the block is idle.
    task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FOREGROUND;
        i_cfg_data  <= fg;
        @(posedge i_clk);
        i_cfg_index <= CFG_BACKGROUND;
        i_cfg_data  <= bg;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_fg = fg;
        cur_bg = bg;
        color_changes++;
    endtask

    // Item driver: offers the oldest pending item and predicts it once accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_cells.push_back(console_step(i_item));
                void'(pending_items.pop_front());
                items_sent++;
                push_gap = pick_gap(push_burst);
            end
            if (push && full) begin
                full_cycles++;
            end else if (push_gap > 0) begin
                push_gap--;
                push <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items[0];
                push   <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result monitor: checks each popped result against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_cells.size() == 0) begin
                    $display("%0t ns: result %0h arrived with no item outstanding",
                             $time, o_result);
                    error_count++;
                end else begin
                    exp_r = expected_cells.pop_front();
                    check_field("write_valid", 16'(exp_r.write_valid), 16'(o_result.write_valid));
                    check_field("cell_index", 16'(exp_r.cell_index), 16'(o_result.cell_index));
                    check_field("cell_value", exp_r.cell_value, o_result.cell_value);
                    check_field("screen_cleared", 16'(exp_r.screen_cleared),
                                16'(o_result.screen_cleared));
                    check_field("cursor_x", 16'(exp_r.cursor_x), 16'(o_result.cursor_x));
                    check_field("cursor_y", 16'(exp_r.cursor_y), 16'(o_result.cursor_y));
                    if (exp_r.screen_cleared) clears_seen++;
                    if (exp_r.write_valid) writes_seen++;
                end
                results_seen++;
                pop_gap = pick_gap(pop_burst);
                // Now and then stop reading long enough for both queues to fill.
                if (results_seen % 350 == 0) hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Run limit well beyond the slowest legal run.
    initial begin
        #6_000_000;
        $display("tb_text_console_cursor_writer NOT OK");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset colors.
        queue_item(OP_PUT_MAIN, 8'h41, 7'd0, 5'd0);
        queue_item(OP_PUT_MAIN, 8'hFF, 7'd127, 5'd31);
        queue_item(OP_PUT_MAIN, 8'h01, 7'd0, 5'd0);
        queue_item(OP_PUT_MAIN, CHAR_END, 7'd0, 5'd0);
        queue_item(OP_PUT_MAIN, CHAR_BACKSPACE, 7'd0, 5'd0);
        queue_item(OP_HOME_MAIN, 8'hFF, 7'd127, 5'd31);
        // Backspace at column zero stays put and blanks the cell.
        queue_item(OP_PUT_MAIN, CHAR_BACKSPACE, 7'd0, 5'd0);
        queue_item(OP_PUT_MAIN, CHAR_NEWLINE, 7'd0, 5'd0);
        // Write at the last cell: the same item wraps, clears and homes.
        queue_item(OP_LOAD_SIDE, 8'h00, 7'd79, 5'd24);
        queue_item(OP_PUT_SIDE, 8'h7E, 7'd0, 5'd0);
        // Out of range loads saturate to the last column and row.
        queue_item(OP_LOAD_SIDE, 8'hFF, 7'd127, 5'd31);
        queue_item(OP_PUT_SIDE, CHAR_NEWLINE, 7'd0, 5'd0);
        queue_item(OP_LOAD_SIDE, 8'h00, 7'd80, 5'd25);
        queue_item(OP_PUT_SIDE, CHAR_BACKSPACE, 7'd0, 5'd0);
        queue_item(OP_LOAD_SIDE, 8'h00, 7'd0, 5'd0);
        queue_item(OP_PUT_SIDE, CHAR_BACKSPACE, 7'd0, 5'd0);
        queue_item(OP_PUT_SIDE, CHAR_END, 7'd0, 5'd0);
        // Print in the last column wraps to the next line.
        queue_item(OP_LOAD_SIDE, 8'h00, 7'd79, 5'd3);
        queue_item(OP_PUT_SIDE, 8'h62, 7'd0, 5'd0);
        queue_item(OP_PUT_SIDE, CHAR_NEWLINE, 7'd0, 5'd0);
        queue_item(OP_PUT_MAIN, CHAR_BLANK, 7'd0, 5'd0);
        queue_item(OP_HOME_MAIN, 8'h00, 7'd0, 5'd0);
        wait_drained();

        // Random phases, each under its own color setting.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       write_colors(4'h0, 4'hF);
                1:       write_colors(4'hF, 4'hF);
                2:       write_colors(4'h0, 4'h0);
                default: write_colors(4'($urandom), 4'($urandom));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_items.push_back(random_item());
            wait_drained();
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items and checked %0d results (%0d cell writes, %0d screen clears).",
                 items_sent, results_seen, writes_seen, clears_seen);
        $display("Used %0d color settings; input was held off by a full queue for %0d cycles.",
                 color_changes + 1, full_cycles);
        if (error_count == 0 && expected_cells.size() == 0) begin
            $display("tb_text_console_cursor_writer OK");
        end else begin
            $display("tb_text_console_cursor_writer NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
